/* hw/rtl/cvlg_pkg.sv */
// ============================================================================
// cvlg_pkg - shared types and constants of the composite video line generator
// Line geometry, line kinds, opcodes, register indexes and the words that
// travel between the sequencer, the output stage and the ports.
// ============================================================================
package cvlg_pkg;

    // Line geometry
    localparam int LINE_WIDTH      = 256;
    localparam int PORCH_SAMPLES   = 20;
    localparam int TOP_PORCH_LINES = 30;
    localparam int IMAGE_LINES     = 192;

    // Frame store
    localparam int STORE_DEPTH = 49152;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int PIXEL_W     = 3;

    // Sample position counter
    localparam int                POS_W        = 10;
    localparam logic [POS_W-1:0]  POS_PAST_END = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]  LINE_LEN     = POS_W'(PORCH_SAMPLES + LINE_WIDTH);
    localparam logic [POS_W-1:0]  PORCH_LEN    = POS_W'(PORCH_SAMPLES);

    // Line classification
    localparam logic [7:0] TOP_LINE   = 8'(TOP_PORCH_LINES);
    localparam logic [8:0] IMAGE_END  = 9'(TOP_PORCH_LINES + IMAGE_LINES);
    localparam logic [7:0] VSYNC_LINE = 8'd255;

    // Address arithmetic width (row times line width plus column)
    localparam int ADDR_CALC_W = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_HIGH   = 3'd4;

    typedef enum logic [1:0] {
        KIND_PORCH = 2'd0,
        KIND_IMAGE = 2'd1,
        KIND_BLANK = 2'd2,
        KIND_VSYNC = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_LINE_START  = 2'd0,
        OP_SAMPLE_TICK = 2'd1,
        OP_PIXEL_WRITE = 2'd2
    } op_t;

    typedef struct packed {
        logic [2:0] sync_level;
        logic [5:0] image_sync_low_samples;
        logic [5:0] blank_sync_low_samples;
        logic [5:0] blank_line_samples;
        logic [5:0] vsync_high_samples;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pixel_addr;
        logic [2:0]  pixel_value;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  dac_level;
        logic [7:0]  line_number;
        logic [8:0]  sample_index;
        logic        line_done;
        logic [31:0] frame_count;
    } out_word_t;

    // Sample tick in flight between the sequencer and the output stage
    typedef struct packed {
        logic [2:0]  base_level;
        logic        pix_en;
        logic [8:0]  sample_index;
        logic        line_done;
        logic [7:0]  line_number;
        logic [31:0] frame_count;
    } tick_t;

    // Frame store access issued by the sequencer
    typedef struct packed {
        logic                en;
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [PIXEL_W-1:0]  wdata;
    } ram_req_t;

endpackage

/* hw/rtl/cvlg_ram.sv */
// ============================================================================
// cvlg_ram - generic single-port synchronous RAM
// One access per cycle; read data is registered and holds between reads.
// ============================================================================
module cvlg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/cvlg_seq.sv */
// ============================================================================
// cvlg_seq - line sequencer
// Holds the line counter, line kind, sample position and frame counter,
// classifies each accepted word and issues frame store accesses.
// ============================================================================
module cvlg_seq
    import cvlg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_word_t word,
    input  cfg_t     cfg,
    output logic     tick_accept,
    output tick_t    tick,
    output ram_req_t ram_req
);

    logic [7:0]       line_counter_reg, line_counter_next;
    logic [7:0]       active_line_reg, active_line_next;
    kind_t            kind_reg, kind_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      frame_reg, frame_next;

    logic [POS_W-1:0]       len;
    logic                   in_line;
    logic                   in_porch;
    logic [POS_W-1:0]       seg;
    logic [POS_W-1:0]       col;
    logic [2:0]             sync;
    logic [7:0]             row;
    logic [ADDR_CALC_W-1:0] rd_addr;
    logic                   rd_ok;
    logic                   wr_ok;

    // Line length and position within the current segment
    always_comb
    begin
        len      = (kind_reg == KIND_BLANK) ? {4'd0, cfg.blank_line_samples} : LINE_LEN;
        in_line  = pos_reg < len;
        in_porch = (kind_reg == KIND_BLANK) || (pos_reg < PORCH_LEN);
        col      = pos_reg - PORCH_LEN;
        seg      = in_porch ? pos_reg : col;
    end

    // Sync pattern level for the segment position
    always_comb
    begin
        case (kind_reg)
            KIND_BLANK:
                sync = (seg < {4'd0, cfg.blank_sync_low_samples}) ? 3'd0 : cfg.sync_level;
            KIND_VSYNC:
                sync = (seg < {4'd0, cfg.vsync_high_samples}) ? cfg.sync_level : 3'd0;
            default:
                sync = (seg < {4'd0, cfg.image_sync_low_samples}) ? 3'd0 : cfg.sync_level;
        endcase
    end

    // Frame store address of the pixel under this sample
    always_comb
    begin
        row     = active_line_reg - TOP_LINE;
        rd_addr = ADDR_CALC_W'(row) * ADDR_CALC_W'(LINE_WIDTH) + ADDR_CALC_W'(col);
        rd_ok   = (kind_reg == KIND_IMAGE) && !in_porch
                  && (rd_addr < ADDR_CALC_W'(STORE_DEPTH));
        wr_ok   = {2'd0, word.pixel_addr} < ADDR_CALC_W'(STORE_DEPTH);
    end

    // Build the tick word and the store access
    always_comb
    begin
        tick_accept       = accept && (word.op == OP_SAMPLE_TICK);
        tick.base_level   = in_line ? sync : 3'd0;
        tick.pix_en       = in_line && rd_ok;
        tick.sample_index = in_line ? pos_reg[8:0] : 9'd0;
        tick.line_done    = !in_line;
        tick.line_number  = active_line_reg;
        tick.frame_count  = frame_reg;

        ram_req.en    = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.addr  = rd_addr[STORE_AW-1:0];
        ram_req.wdata = word.pixel_value;
        if (accept && (word.op == OP_PIXEL_WRITE) && wr_ok)
        begin
            ram_req.en   = 1'b1;
            ram_req.we   = 1'b1;
            ram_req.addr = word.pixel_addr[STORE_AW-1:0];
        end
        else if (tick_accept && in_line && rd_ok)
        begin
            ram_req.en = 1'b1;
        end
    end

    // Advance line and sample state
    always_comb
    begin
        line_counter_next = line_counter_reg;
        active_line_next  = active_line_reg;
        kind_next         = kind_reg;
        pos_next          = pos_reg;
        frame_next        = frame_reg;
        if (accept && (word.op == OP_LINE_START))
        begin
            if (line_counter_reg < TOP_LINE)
            begin
                kind_next = KIND_PORCH;
            end
            else if ({1'b0, line_counter_reg} < IMAGE_END)
            begin
                kind_next = KIND_IMAGE;
            end
            else if (line_counter_reg < VSYNC_LINE)
            begin
                kind_next = KIND_BLANK;
            end
            else
            begin
                kind_next  = KIND_VSYNC;
                frame_next = frame_reg + 32'd1;
            end
            active_line_next  = line_counter_reg;
            pos_next          = '0;
            line_counter_next = line_counter_reg + 8'd1;
        end
        else if (tick_accept && in_line)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_counter_reg <= '0;
            active_line_reg  <= '0;
            kind_reg         <= KIND_BLANK;
            pos_reg          <= POS_PAST_END;
            frame_reg        <= '0;
        end
        else
        begin
            line_counter_reg <= line_counter_next;
            active_line_reg  <= active_line_next;
            kind_reg         <= kind_next;
            pos_reg          <= pos_next;
            frame_reg        <= frame_next;
        end
    end

endmodule

/* hw/rtl/cvlg_out.sv */
// ============================================================================
// cvlg_out - level assembly and output stage
// Holds each tick in an assembly register beside the registered frame store
// read, adds the pixel to the sync level, tracks the held level and drives the output register.
// ============================================================================
module cvlg_out
    import cvlg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_accept,
    input  tick_t              tick,
    input  logic [PIXEL_W-1:0] pixel,
    output logic               ready,
    output logic               valid,
    input  logic               out_ready,
    output out_word_t          word
);

    logic      s1_valid_reg, s1_valid_next;
    tick_t     s1_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg;
    logic [3:0] held_reg, held_next;
    logic      s1_advance;
    logic [3:0] level;

    // Move the pending tick forward when the output register frees up
    always_comb
    begin
        s1_advance     = s1_valid_reg && (!out_valid_reg || out_ready);
        ready          = !s1_valid_reg || s1_advance;
        s1_valid_next  = tick_accept || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && !out_ready);
    end

    // Add the pixel, or hold the last level once the line is exhausted
    always_comb
    begin
        level     = {1'b0, s1_reg.base_level} + (s1_reg.pix_en ? {1'b0, pixel} : 4'd0);
        held_next = held_reg;
        if (s1_advance && !s1_reg.line_done)
        begin
            held_next = level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            s1_reg <= tick;
        end
        if (s1_advance)
        begin
            out_reg.dac_level    <= s1_reg.line_done ? held_reg : level;
            out_reg.line_number  <= s1_reg.line_number;
            out_reg.sample_index <= s1_reg.sample_index;
            out_reg.line_done    <= s1_reg.line_done;
            out_reg.frame_count  <= s1_reg.frame_count;
        end
    end

    assign valid = out_valid_reg;
    assign word  = out_reg;

endmodule

/* hw/rtl/composite_video_line_generator.sv */
// ============================================================================
// composite_video_line_generator - composite video DAC level generator
// Emits one DAC level per sample tick from a line sequencer and frame store.
// ============================================================================
// Usage:
//   in_valid/in_ready carry a word with op, pixel_addr and pixel_value:
//   line_start opens the next of 256 lines, pixel_write fills the frame
//   store, sample_tick asks for one DAC level. Only sample_tick gives a
//   result word on out_valid/out_ready.
//   A taken tick is registered in the assembly stage together with its
//   store read data, where the level is assembled, and then moves on to
//   the output register. One word of any kind is taken every cycle while
//   in_ready is high; the single-port frame store serves one write or one
//   read per cycle, which sets that rate.
//   When the receiver stalls, one tick waits in the assembly stage and one
//   in the output register; after that in_ready drops until out_ready rises.
//   Reset clears the line counter, frame counter and held level, sets the
//   registers to their defaults and leaves the line exhausted, so ticks give
//   the held level with line_done set. The frame store is not cleared.
//   Configuration writes via cfg_we/cfg_index/cfg_data are registered in cfg_reg before they take effect.
// ============================================================================
module composite_video_line_generator
    import cvlg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg, cfg_next;
    logic               accept;
    logic               tick_accept;
    tick_t              tick;
    ram_req_t           ram_req;
    logic [PIXEL_W-1:0] pixel;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_LEVEL: cfg_next.sync_level             = cfg_data[2:0];
                CFG_IMAGE_LOW:  cfg_next.image_sync_low_samples = cfg_data;
                CFG_BLANK_LOW:  cfg_next.blank_sync_low_samples = cfg_data;
                CFG_BLANK_LEN:  cfg_next.blank_line_samples     = cfg_data;
                CFG_VSYNC_HIGH: cfg_next.vsync_high_samples     = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_level             <= 3'd2;
            cfg_reg.image_sync_low_samples <= 6'd15;
            cfg_reg.blank_sync_low_samples <= 6'd4;
            cfg_reg.blank_line_samples     <= 6'd12;
            cfg_reg.vsync_high_samples     <= 6'd4;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = in_valid && in_ready;

    cvlg_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .word        (in_data),
        .cfg         (cfg_reg),
        .tick_accept (tick_accept),
        .tick        (tick),
        .ram_req     (ram_req)
    );

    cvlg_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (pixel)
    );

    cvlg_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_accept (tick_accept),
        .tick        (tick),
        .pixel       (pixel),
        .ready       (in_ready),
        .valid       (out_valid),
        .out_ready   (out_ready),
        .word        (out_data)
    );

endmodule
